>>> hw/rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Types, codes and sizes shared by the address cache table modules.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int unsigned TableEntriesDefault = 16;
  localparam logic [15:0] AgeLimitReset = 16'd300;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_LOOKUP = 3'd2,
    KIND_AGE    = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_OUT  = 2'd2
  } fsm_e;

  localparam int unsigned RegAgeLimit = 0;

  // one entry of the table
  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] hw_type;
    logic [7:0]  flags;
    logic        stat;
    logic [15:0] stamp;
  } entry_t;

  // request word held by the table unit while the ring is scanned
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] hw_type;
    logic [7:0]  flags;
    logic        stat;
    logic [15:0] now;
  } req_t;

  // command from the sequencer to every cell in the same cycle
  typedef struct packed {
    logic shift;  // rotate entries one place
    logic clear;  // invalidate all
  } ctrl_t;

endpackage

>>> hw/rtl/arp_cell.sv
// ----------------------------------------------------------------------------
// arp_cell
// One table slot in a rotating ring: holds an entry and passes it on.
// ----------------------------------------------------------------------------
module arp_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  arp_pkg::ctrl_t       ctrl_i,
  input  arp_pkg::entry_t      prev_i,
  input  logic                 wr_i,
  input  arp_pkg::entry_t      wr_entry_i,
  output arp_pkg::entry_t      entry_o
);
  import arp_pkg::*;

  entry_t ent_q, ent_d;
  logic   valid_q;

  always_comb begin
    ent_d = ent_q;
    ent_d.valid = valid_q;
    if (ctrl_i.shift) begin
      ent_d = wr_i ? wr_entry_i : prev_i;
    end
    if (ctrl_i.clear) begin
      ent_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ent_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_comb begin
    entry_o = ent_q;
    entry_o.valid = valid_q;
  end
endmodule

>>> hw/rtl/arp_cache_table_unit.sv
// ----------------------------------------------------------------------------
// arp_cache_table_unit
// Address cache table built as a ring of slot cells turned twice per request.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                       Contents
// s_axis   in   s_axis_tvalid/tready/tdata     request (kind in tuser)
// m_axis   out  m_axis_tvalid/tready/tdata     result
// apb      in   psel/penable/pwrite/paddr      age_limit at address 0
//
// The ring turns twice per request: the first turn finds the lowest match
// and the lowest free slot, the second applies the write. The result is
// registered after the second turn; a new request is taken only when the
// unit is idle and no result waits. Reset empties the table at once. A
// result held by m_axis_tready stalls the next request; the result register
// holds its contents.
module arp_cache_table_unit #(
  parameter int unsigned TABLE_ENTRIES = arp_pkg::TableEntriesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata bits: ip_addr[31:0], mac[79:32], hw_type[95:80],
  // entry_flags[103:96], static_mark[104], now_seconds[120:105], zero to 127
  input  logic [127:0] s_axis_tdata,
  // tuser bits: kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata bits: status[1:0], hit[2], found_mac[50:3], found_hw_type[66:51],
  // found_flags[74:67], zero to 79
  output logic [79:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import arp_pkg::*;

  localparam int unsigned CntW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES + 1) : 1;

  fsm_e   state_q, state_d;
  req_t   req_q;
  ctrl_t  ctrl;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0] age_limit_q;

  // scan results
  logic        match_q, free_q, done_q;
  logic        match_d, free_d, done_d;
  logic [CntW-1:0] match_pos_q, free_pos_q, match_pos_d, free_pos_d;
  logic [47:0] fmac_q, fmac_d;
  logic [15:0] fhw_q, fhw_d;
  logic [7:0]  fflg_q, fflg_d;

  entry_t ent [TABLE_ENTRIES];
  entry_t head, wr_entry;
  logic   wr_head;
  logic [15:0] age;
  logic   hmatch;

  logic        out_valid_q;
  logic [79:0] out_data_q;

  // APB
  assign pready = 1'b1;
  assign prdata = (paddr == 2'(RegAgeLimit)) ? {16'd0, age_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_limit_q <= AgeLimitReset;
    end else if (psel && penable && pwrite && paddr == 2'(RegAgeLimit)) begin
      age_limit_q <= pwdata[15:0];
    end
  end

  // ring: cell i takes from cell i+1, head is cell 0 and wraps to the last
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    entry_t prev;
    logic   wr;
    if (g == TABLE_ENTRIES - 1) begin : g_last
      assign prev = head;
      assign wr   = wr_head;
    end else begin : g_mid
      assign prev = ent[g+1];
      assign wr   = 1'b0;
    end
    arp_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl), .prev_i(prev), .wr_i(wr),
      .wr_entry_i(wr_entry), .entry_o(ent[g])
    );
  end
  assign head = ent[0];

  assign hmatch = head.valid && head.ip == req_q.ip;
  assign age    = req_q.now - head.stamp;

  assign s_axis_tready = (state_q == FSM_IDLE) && !out_valid_q;

  // cnt is the slot index at the head. Pass 0 finds the lowest match and the
  // lowest free slot; pass 1 applies the write, so an insert never claims a
  // free slot ahead of a later match.
  logic pass_q, pass_d;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    pass_d = pass_q;
    ctrl = '0;
    match_d = match_q; free_d = free_q; done_d = done_q;
    match_pos_d = match_pos_q; free_pos_d = free_pos_q;
    fmac_d = fmac_q; fhw_d = fhw_q; fflg_d = fflg_q;
    wr_head = 1'b0;
    wr_entry = head;
    unique case (state_q)
      FSM_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          state_d = FSM_SCAN;
          cnt_d = '0; pass_d = 1'b0;
          match_d = 1'b0; free_d = 1'b0; done_d = 1'b0;
          match_pos_d = '0; free_pos_d = '0;
          fmac_d = '0; fhw_d = '0; fflg_d = '0;
        end
      end
      FSM_SCAN: begin
        ctrl.shift = 1'b1;
        if (!pass_q) begin
          if (hmatch && !match_q) begin
            match_d = 1'b1; match_pos_d = cnt_q;
            fmac_d = head.mac; fhw_d = head.hw_type; fflg_d = head.flags;
          end
          if (!head.valid && !free_q) begin
            free_d = 1'b1; free_pos_d = cnt_q;
          end
        end else begin
          unique case (req_q.kind)
            KIND_INSERT: begin
              if ((match_q && cnt_q == match_pos_q) ||
                  (!match_q && free_q && cnt_q == free_pos_q)) begin
                wr_head = 1'b1;
                wr_entry = '{valid: 1'b1, ip: req_q.ip, mac: req_q.mac,
                             hw_type: req_q.hw_type, flags: req_q.flags,
                             stat: req_q.stat, stamp: req_q.now};
              end
            end
            KIND_REMOVE: begin
              if (match_q && cnt_q == match_pos_q && head.mac == req_q.mac) begin
                wr_head = 1'b1; wr_entry.valid = 1'b0;
              end
            end
            KIND_AGE: begin
              if (!done_q && head.valid && !head.stat && age >= age_limit_q) begin
                wr_head = 1'b1; wr_entry.valid = 1'b0; done_d = 1'b1;
              end
            end
            KIND_CLEAR: begin
              wr_head = 1'b1; wr_entry.valid = 1'b0;
            end
            default: ;
          endcase
        end
        if (cnt_q == CntW'(TABLE_ENTRIES - 1)) begin
          cnt_d = '0;
          pass_d = 1'b1;
          if (pass_q) state_d = FSM_OUT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      FSM_OUT: state_d = FSM_IDLE;
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      cnt_q <= '0;
      pass_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      pass_q <= pass_d;
      if (state_q == FSM_OUT) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d; free_q <= free_d; done_q <= done_d;
    match_pos_q <= match_pos_d; free_pos_q <= free_pos_d;
    fmac_q <= fmac_d; fhw_q <= fhw_d; fflg_q <= fflg_d;
    if (s_axis_tvalid && s_axis_tready) begin
      req_q <= '{kind: s_axis_tuser, ip: s_axis_tdata[31:0],
                 mac: s_axis_tdata[79:32], hw_type: s_axis_tdata[95:80],
                 flags: s_axis_tdata[103:96], stat: s_axis_tdata[104],
                 now: s_axis_tdata[120:105]};
    end
  end

  // result register
  logic [1:0] st;
  logic       hit;
  always_comb begin
    st = ST_OK;
    hit = 1'b0;
    unique case (req_q.kind)
      KIND_INSERT: if (!match_q && !free_q) st = ST_NOSPACE;
      KIND_REMOVE: if (!match_q) st = ST_NOTFOUND;
      KIND_LOOKUP: if (!match_q) st = ST_NOTFOUND; else hit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FSM_OUT) begin
      out_data_q <= {5'd0, hit ? fflg_q : 8'd0, hit ? fhw_q : 16'd0,
                     hit ? fmac_q : 48'd0, hit, st};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
endmodule

>>> hw/rtl/arp_checker.sv
// ----------------------------------------------------------------------------
// arp_checker
// Port-level checks on the address cache table, bound to the top level.
// ----------------------------------------------------------------------------
module arp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        pready
);
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // no new request while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken with result pending");
  // a request is never answered in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid && !s_axis_tready)
    else $error("request answered too early");
  // hit only with status ok
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == 2'd0)
    else $error("hit with error status");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
endmodule

bind arp_cache_table_unit arp_checker u_arp_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .pready
);
